// ===== rtl/core/hds_pkg.sv =====
package hds_pkg;

	localparam logic [63:0] SAT_LIM = 64'h0FFF_FFFF_FFFF_FFFF;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam logic [CFG_ADDR_W-1:0] ADDR_TIME_STEP = 4'h0;
	localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH_IN_USE = 4'h4;
	localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT_IN_USE = 4'h8;

	typedef struct packed {
		logic signed [31:0] tracer_old;
		logic signed [31:0] tracer_now;
		logic [30:0] diffusivity;
		logic [30:0] thickness;
		logic [30:0] inv_dx;
		logic [30:0] inv_dy;
		logic [30:0] ratio_u;
		logic [30:0] ratio_v;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] tracer_updated;
		logic [7:0] cell_col;
		logic [7:0] cell_row;
		logic last_of_level;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] told;
		logic [30:0] diff;
		logic [30:0] thick;
	} upper_cell_t;

	typedef enum logic [1:0] {
		SH_METRIC2,
		SH_DATA,
		SH_METRIC
	} sh_sel_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		sh_sel_t sh;
	} mul_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/hds_mul.sv =====
module hds_mul #(
	parameter int DATA_FRAC = 16,
	parameter int METRIC_FRAC = 28
) (
	input logic clk,
	input logic arst_n,
	input hds_pkg::mul_req_t req,
	output logic done,
	output logic signed [63:0] result
);
	import hds_pkg::*;

	logic [63:0] ma_q, mb_q;
	logic neg_q;
	sh_sel_t sh_q;
	logic [2:0] cnt_q;
	logic busy_q, done_q;
	logic [63:0] pp_q;
	logic [1:0] ppsel_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;
	logic [31:0] a_half, b_half;
	logic [127:0] pp_ext, shifted;
	logic [63:0] mag;

	always_comb begin
		a_half = (cnt_q == 3'd2 || cnt_q == 3'd3) ? ma_q[63:32] : ma_q[31:0];
		b_half = (cnt_q == 3'd1 || cnt_q == 3'd3) ? mb_q[63:32] : mb_q[31:0];
		unique case (ppsel_q)
			2'd0: pp_ext = {64'b0, pp_q};
			2'd1: pp_ext = {32'b0, pp_q, 32'b0};
			default: pp_ext = {pp_q, 64'b0};
		endcase
		unique case (sh_q)
			SH_METRIC2: shifted = acc_q >> (METRIC_FRAC + 2);
			SH_DATA: shifted = acc_q >> DATA_FRAC;
			default: shifted = acc_q >> METRIC_FRAC;
		endcase
		mag = (shifted > {64'b0, SAT_LIM}) ? SAT_LIM : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= req.a[63] ? 64'(-req.a) : req.a;
			mb_q <= req.b[63] ? 64'(-req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			sh_q <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				pp_q <= 64'(a_half) * 64'(b_half);
				ppsel_q <= (cnt_q == 3'd0) ? 2'd0 : ((cnt_q == 3'd3) ? 2'd2 : 2'd1);
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
			if (cnt_q == 3'd5) begin
				res_q <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ===== rtl/core/hds_linestore.sv =====
module hds_linestore #(
	parameter int DEPTH = 258
) (
	input logic clk,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr0,
	input logic [$clog2(DEPTH)-1:0] rd_addr1,
	output hds_pkg::in_item_t mid0,
	output hds_pkg::in_item_t mid1,
	output hds_pkg::upper_cell_t up0,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input hds_pkg::in_item_t wr_mid,
	input hds_pkg::upper_cell_t wr_up
);
	import hds_pkg::*;

	in_item_t mid_mem [DEPTH];
	upper_cell_t up_mem [DEPTH];
	in_item_t mid0_q, mid1_q;
	upper_cell_t up0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mid_mem[wr_addr] <= wr_mid;
		end
		if (rd_en) begin
			mid0_q <= mid_mem[rd_addr0];
			mid1_q <= mid_mem[rd_addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			up_mem[wr_addr] <= wr_up;
		end
		if (rd_en) begin
			up0_q <= up_mem[rd_addr0];
		end
	end

	assign mid0 = mid0_q;
	assign mid1 = mid1_q;
	assign up0 = up0_q;

endmodule

// ===== rtl/core/harmonic_diffusion_stencil.sv =====
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_data (in_item_t), one grid cell incl. halo
// out       out_valid / out_ready out_data (out_item_t), one updated interior cell
// config    APB write/read        time_step, width_in_use, height_in_use
// A halo cell returns to idle once the line stores are updated; an interior cell takes
// fifteen passes through the single 32x32 multiplier that builds each 64-bit product
// from four partial products. The line stores are read at acceptance and written back
// at the end of the following cycle. Reset clears the counters, the neighbor cell and
// the output valid flag; the output data register and the line stores need no clearing.
// A new transaction is taken while a result waits on the output; the next result
// holds in its final state until the output register is free.
module harmonic_diffusion_stencil #(
	parameter int TILE_X = 256,
	parameter int TILE_Y = 256,
	parameter int DATA_FRAC = 16,
	parameter int METRIC_FRAC = 28
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hds_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output hds_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [hds_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hds_pkg::*;

	localparam int DEPTH = TILE_X + 2;
	localparam int CW = $clog2(DEPTH);
	localparam int RW = $clog2(TILE_Y + 2);

	state_t state_q, state_d;
	logic [31:0] time_step_q;
	logic [8:0] width_q, height_q;
	logic [CW-1:0] c_q, w_cl;
	logic [RW-1:0] r_q, h_cl;
	in_item_t cur_q, ctr_q, rgt_q, lft_q, prev_q;
	upper_cell_t up_q;
	in_item_t mid0, mid1;
	upper_cell_t up0;
	logic [7:0] col_q, row_q;
	logic last_q;
	logic [1:0] face_q, phase_q;
	logic tail_q;
	logic signed [63:0] flux_q [4];
	logic out_valid_q;
	out_item_t out_q;
	mul_req_t mreq;
	logic mdone;
	logic signed [63:0] mres;
	logic accept, interior, slot_free;
	logic [30:0] fa_d, fb_d, fa_h, fb_h, f_ratio;
	logic signed [31:0] fa_t, fb_t;
	logic signed [63:0] div, sum;
	logic signed [31:0] sat;

	assign pready = 1'b1;
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		w_cl = (32'(width_q) > TILE_X) ? CW'(TILE_X) :
			((width_q == 9'd0) ? CW'(1) : CW'(width_q));
		h_cl = (32'(height_q) > TILE_Y) ? RW'(TILE_Y) :
			((height_q == 9'd0) ? RW'(1) : RW'(height_q));
		interior = (r_q >= RW'(2)) && ({1'b0, r_q} <= {1'b0, h_cl} + (RW+1)'(1)) &&
			(c_q >= CW'(1)) && (c_q <= w_cl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_TIME_STEP: time_step_q <= pwdata;
				ADDR_WIDTH_IN_USE: width_q <= pwdata[8:0];
				ADDR_HEIGHT_IN_USE: height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_TIME_STEP: prdata = time_step_q;
			ADDR_WIDTH_IN_USE: prdata = {23'b0, width_q};
			ADDR_HEIGHT_IN_USE: prdata = {23'b0, height_q};
			default: prdata = '0;
		endcase
	end

	hds_linestore #(.DEPTH(DEPTH)) u_store (
		.clk(clk),
		.rd_en(accept),
		.rd_addr0(c_q),
		.rd_addr1(c_q + CW'(1)),
		.mid0(mid0),
		.mid1(mid1),
		.up0(up0),
		.wr_en(state_q == ST_READ),
		.wr_addr(c_q),
		.wr_mid(cur_q),
		.wr_up({mid0.tracer_old, mid0.diffusivity, mid0.thickness})
	);

	always_comb begin
		unique case (face_q)
			2'd0: begin
				fa_d = ctr_q.diffusivity; fb_d = lft_q.diffusivity;
				fa_h = ctr_q.thickness; fb_h = lft_q.thickness;
				fa_t = ctr_q.tracer_old; fb_t = lft_q.tracer_old;
				f_ratio = ctr_q.ratio_u;
			end
			2'd1: begin
				fa_d = rgt_q.diffusivity; fb_d = ctr_q.diffusivity;
				fa_h = rgt_q.thickness; fb_h = ctr_q.thickness;
				fa_t = rgt_q.tracer_old; fb_t = ctr_q.tracer_old;
				f_ratio = rgt_q.ratio_u;
			end
			2'd2: begin
				fa_d = ctr_q.diffusivity; fb_d = up_q.diff;
				fa_h = ctr_q.thickness; fb_h = up_q.thick;
				fa_t = ctr_q.tracer_old; fb_t = up_q.told;
				f_ratio = ctr_q.ratio_v;
			end
			default: begin
				fa_d = cur_q.diffusivity; fb_d = ctr_q.diffusivity;
				fa_h = cur_q.thickness; fb_h = ctr_q.thickness;
				fa_t = cur_q.tracer_old; fb_t = ctr_q.tracer_old;
				f_ratio = cur_q.ratio_v;
			end
		endcase
		div = (flux_q[1] - flux_q[0]) + (flux_q[3] - flux_q[2]);
		mreq.start = (state_q == ST_MUL);
		mreq.a = mres;
		mreq.b = '0;
		mreq.sh = SH_DATA;
		if (!tail_q) begin
			unique case (phase_q)
				2'd0: begin
					mreq.a = $signed({32'b0, 32'(fa_d) + 32'(fb_d)});
					mreq.b = $signed({33'b0, f_ratio});
					mreq.sh = SH_METRIC2;
				end
				2'd1: mreq.b = $signed({32'b0, 32'(fa_h) + 32'(fb_h)});
				default: mreq.b = 64'(33'(fa_t) - 33'(fb_t));
			endcase
		end else begin
			unique case (phase_q)
				2'd0: begin
					mreq.a = $signed({32'b0, time_step_q});
					mreq.b = $signed({33'b0, ctr_q.inv_dx});
					mreq.sh = SH_METRIC;
				end
				2'd1: begin
					mreq.b = $signed({33'b0, ctr_q.inv_dy});
					mreq.sh = SH_METRIC;
				end
				default: mreq.b = div;
			endcase
		end
		sum = 64'(ctr_q.tracer_now) + mres;
		if (sum > 64'sd2147483647) begin
			sat = 32'sh7FFF_FFFF;
		end else if (sum < -64'sd2147483648) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = sum[31:0];
		end
	end

	hds_mul #(.DATA_FRAC(DATA_FRAC), .METRIC_FRAC(METRIC_FRAC)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mdone),
		.result(mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_READ;
			end
			ST_READ: state_d = interior ? ST_MUL : ST_IDLE;
			ST_MUL: state_d = ST_WAIT;
			ST_WAIT: begin
				if (mdone) state_d = (tail_q && phase_q == 2'd2) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
			face_q <= '0;
			phase_q <= '0;
			tail_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_READ: begin
					prev_q <= mid0;
					face_q <= '0;
					phase_q <= '0;
					tail_q <= 1'b0;
					if (c_q >= w_cl + CW'(1)) begin
						c_q <= '0;
						r_q <= (r_q >= h_cl + RW'(1)) ? '0 : r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				ST_WAIT: begin
					if (mdone) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							if (!tail_q) begin
								if (face_q == 2'd3) tail_q <= 1'b1;
								else face_q <= face_q + 2'd1;
							end
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cur_q <= in_data;
		if (state_q == ST_READ) begin
			ctr_q <= mid0;
			rgt_q <= mid1;
			up_q <= up0;
			lft_q <= prev_q;
			col_q <= 8'(c_q - CW'(1));
			row_q <= 8'(r_q - RW'(2));
			last_q <= (c_q == w_cl) && ({1'b0, r_q} == {1'b0, h_cl} + (RW+1)'(1));
		end
		if (state_q == ST_WAIT && mdone && !tail_q && phase_q == 2'd2) begin
			flux_q[face_q] <= mres;
		end
		if (state_q == ST_DONE && slot_free) begin
			out_q.tracer_updated <= sat;
			out_q.cell_col <= col_q;
			out_q.cell_row <= row_q;
			out_q.last_of_level <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hds_pkg::*;

	localparam int TILE_X = 256;
	localparam int TILE_Y = 256;
	localparam int DATA_FRAC = 16;
	localparam int METRIC_FRAC = 28;
	localparam int STALL_LIMIT = 10000;
	localparam int LONG_HOLD = 1500;

	typedef enum int {
		CELL_TYPICAL,
		CELL_RANDOM,
		CELL_MAX,
		CELL_MIN
	} cell_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	harmonic_diffusion_stencil i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	in_item_t cell_q[$];
	out_item_t updated_q[$];

	logic [31:0] dt_reg = 32'd0;
	logic [8:0] width_reg = 9'd256;
	logic [8:0] height_reg = 9'd256;
	upper_cell_t upper_row[TILE_X+2];
	in_item_t middle_row[TILE_X+2];
	in_item_t left_cell = '0;
	int col_cnt = 0;
	int row_cnt = 0;

	int fail_count = 0;
	int cells_sent = 0;
	int cells_taken = 0;
	int results_seen = 0;
	int levels_run = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int out_stall = 0;
	bit calm = 1'b0;
	bit long_hold_done = 1'b0;
	bit in_fire;

	function automatic logic signed [63:0] fixed_mul(logic signed [63:0] a,
			logic signed [63:0] b, int sh);
		logic neg;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [127:0] prod;
		neg = a[63] ^ b[63];
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		prod = prod >> sh;
		if (prod > {64'd0, SAT_LIM}) prod = {64'd0, SAT_LIM};
		return neg ? -prod[63:0] : prod[63:0];
	endfunction

	function automatic logic signed [63:0] face_flux(logic [30:0] da, logic [30:0] db,
			logic [30:0] ratio, logic [30:0] ha, logic [30:0] hb,
			logic signed [31:0] ta, logic signed [31:0] tb);
		logic signed [63:0] k;
		logic signed [63:0] kh;
		logic signed [63:0] tdiff;
		k = fixed_mul(64'(da) + 64'(db), 64'(ratio), METRIC_FRAC + 2);
		kh = fixed_mul(k, 64'(ha) + 64'(hb), DATA_FRAC);
		tdiff = 64'(ta) - 64'(tb);
		return fixed_mul(kh, tdiff, DATA_FRAC);
	endfunction

	function automatic int clamp_size(logic [8:0] v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic diffuse_cell(in_item_t cur);
		int w;
		int h;
		int c;
		in_item_t ctr;
		in_item_t rgt;
		upper_cell_t up;
		logic signed [63:0] fx_l;
		logic signed [63:0] fx_r;
		logic signed [63:0] fe_u;
		logic signed [63:0] fe_d;
		logic signed [63:0] div;
		logic signed [63:0] cff;
		logic signed [63:0] res;
		out_item_t upd;
		w = clamp_size(width_reg, TILE_X);
		h = clamp_size(height_reg, TILE_Y);
		c = (col_cnt >= TILE_X + 2) ? TILE_X + 1 : col_cnt;
		ctr = middle_row[c];
		if (row_cnt >= 2 && row_cnt <= h + 1 && c >= 1 && c <= w) begin
			rgt = middle_row[c+1];
			up = upper_row[c];
			fx_l = face_flux(ctr.diffusivity, left_cell.diffusivity, ctr.ratio_u,
				ctr.thickness, left_cell.thickness, ctr.tracer_old, left_cell.tracer_old);
			fx_r = face_flux(rgt.diffusivity, ctr.diffusivity, rgt.ratio_u,
				rgt.thickness, ctr.thickness, rgt.tracer_old, ctr.tracer_old);
			fe_u = face_flux(ctr.diffusivity, up.diff, ctr.ratio_v,
				ctr.thickness, up.thick, ctr.tracer_old, up.told);
			fe_d = face_flux(cur.diffusivity, ctr.diffusivity, cur.ratio_v,
				cur.thickness, ctr.thickness, cur.tracer_old, ctr.tracer_old);
			div = (fx_r - fx_l) + (fe_d - fe_u);
			cff = fixed_mul(fixed_mul(64'(dt_reg), 64'(ctr.inv_dx), METRIC_FRAC),
				64'(ctr.inv_dy), METRIC_FRAC);
			res = 64'(ctr.tracer_now) + fixed_mul(cff, div, DATA_FRAC);
			if (res > 64'sd2147483647) res = 64'sd2147483647;
			if (res < -64'sd2147483648) res = -64'sd2147483648;
			upd.tracer_updated = res[31:0];
			upd.cell_col = 8'(c - 1);
			upd.cell_row = 8'(row_cnt - 2);
			upd.last_of_level = (c == w && row_cnt == h + 1);
			updated_q.push_back(upd);
		end
		left_cell = ctr;
		upper_row[c].told = ctr.tracer_old;
		upper_row[c].diff = ctr.diffusivity;
		upper_row[c].thick = ctr.thickness;
		middle_row[c] = cur;
		if (c >= w + 1) begin
			col_cnt = 0;
			row_cnt = (row_cnt >= h + 1) ? 0 : row_cnt + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic in_item_t make_cell(cell_kind_t kind);
		in_item_t item;
		case (kind)
			CELL_MAX: begin
				item = '1;
				item.tracer_old = 32'sh7FFF_FFFF;
				item.tracer_now = 32'sh7FFF_FFFF;
			end
			CELL_MIN: begin
				item = '0;
				item.tracer_old = 32'sh8000_0000;
				item.tracer_now = 32'sh8000_0000;
			end
			CELL_RANDOM: begin
				item.tracer_old = $urandom();
				item.tracer_now = $urandom();
				item.diffusivity = 31'($urandom());
				item.thickness = 31'($urandom());
				item.inv_dx = 31'($urandom());
				item.inv_dy = 31'($urandom());
				item.ratio_u = 31'($urandom());
				item.ratio_v = 31'($urandom());
			end
			default: begin
				item.tracer_old = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
				item.tracer_now = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
				item.diffusivity = 31'($urandom_range(0, 32'h0040_0000));
				item.thickness = 31'($urandom_range(0, 32'h0040_0000));
				item.inv_dx = 31'($urandom_range(0, 32'h0100_0000));
				item.inv_dy = 31'($urandom_range(0, 32'h0100_0000));
				item.ratio_u = 31'($urandom_range(0, 32'h2000_0000));
				item.ratio_v = 31'($urandom_range(0, 32'h2000_0000));
			end
		endcase
		return item;
	endfunction

	task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (cell_q.size() != 0 || in_valid || updated_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// directed: 0 = alternate extremes, 1 = extremes and full random, 2 = random content
	task automatic run_level(logic [31:0] dt, logic [8:0] w, logic [8:0] h, int directed);
		int n;
		int pick;
		wait_drained();
		cfg_write(ADDR_TIME_STEP, dt);
		cfg_write(ADDR_WIDTH_IN_USE, 32'(w));
		cfg_write(ADDR_HEIGHT_IN_USE, 32'(h));
		dt_reg = dt;
		width_reg = w;
		height_reg = h;
		calm = ($urandom_range(0, 3) == 0);
		n = (clamp_size(w, TILE_X) + 2) * (clamp_size(h, TILE_Y) + 2);
		for (int i = 0; i < n; i++) begin
			if (directed == 0) begin
				cell_q.push_back(make_cell((i % 2) ? CELL_MIN : CELL_MAX));
			end else if (directed == 1) begin
				pick = i % 3;
				cell_q.push_back(make_cell(pick == 0 ? CELL_MAX :
					(pick == 1 ? CELL_MIN : CELL_RANDOM)));
			end else begin
				pick = $urandom_range(0, 99);
				cell_q.push_back(make_cell(pick < 75 ? CELL_TYPICAL :
					(pick < 93 ? CELL_RANDOM : (pick < 97 ? CELL_MAX : CELL_MIN))));
			end
		end
		cells_sent += n;
		levels_run++;
	endtask

	function automatic logic [31:0] pick_dt();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return $urandom_range(0, 32'h0010_0000);
		if (r < 8) return $urandom();
		return (r == 8) ? 32'd0 : 32'hFFFF_FFFF;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				diffuse_cell(in_data);
				cells_taken++;
			end
			if (in_valid && !in_fire) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (cell_q.size() > 0) begin
				in_data <= cell_q.pop_front();
				in_valid <= 1'b1;
				in_gap = calm ? 0 : gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (updated_q.size() == 0) begin
					$error("unexpected result transaction: %p", out_data);
					fail_count++;
				end else begin
					out_item_t exp_upd;
					exp_upd = updated_q.pop_front();
					if (out_data.tracer_updated !== exp_upd.tracer_updated) begin
						$error("tracer_updated expected %0d actual %0d",
							exp_upd.tracer_updated, out_data.tracer_updated);
						fail_count++;
					end
					if (out_data.cell_col !== exp_upd.cell_col) begin
						$error("cell_col expected %0d actual %0d",
							exp_upd.cell_col, out_data.cell_col);
						fail_count++;
					end
					if (out_data.cell_row !== exp_upd.cell_row) begin
						$error("cell_row expected %0d actual %0d",
							exp_upd.cell_row, out_data.cell_row);
						fail_count++;
					end
					if (out_data.last_of_level !== exp_upd.last_of_level) begin
						$error("last_of_level expected %0d actual %0d",
							exp_upd.last_of_level, out_data.last_of_level);
						fail_count++;
					end
				end
			end
			if (!long_hold_done && results_seen == 20) begin
				long_hold_done = 1'b1;
				out_stall = LONG_HOLD;
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_stall = calm ? 0 : gap_len();
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", idle_cycles);
				$display("harmonic_diffusion_stencil test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_level(32'd0, 9'd1, 9'd1, 0);
		run_level(32'hFFFF_FFFF, 9'd2, 9'd1, 1);
		run_level(32'h0001_0000, 9'd120, 9'd1, 2);
		run_level(pick_dt(), 9'd0, 9'd3, 2);
		run_level(pick_dt(), 9'd3, 9'd0, 2);
		while (cells_sent < 560)
			run_level(pick_dt(), 9'($urandom_range(1, 8)), 9'($urandom_range(1, 6)), 2);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Ran %0d levels, %0d cells in, %0d updated cells checked.",
			levels_run, cells_taken, results_seen);
		$display("Sizes from 1 to 120 cells, zero sizes, and time steps 0 and max.");
		if (fail_count == 0) begin
			$display("harmonic_diffusion_stencil test passed");
		end else begin
			$display("harmonic_diffusion_stencil test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hds_pkg.sv
rtl/core/hds_mul.sv
rtl/core/hds_linestore.sv
rtl/core/harmonic_diffusion_stencil.sv
verif/tb_top.sv
